// ----- hdl/fsrq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the weight table for the fair-share run queue.
// Has no dependencies; every other file imports it.
package fsrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int NICE_MAX        = 30;
  localparam int CMD_W           = 2;
  localparam int ID_W            = 6;
  localparam int VR_W            = 31;
  localparam int NICE_W          = 7;
  localparam int TICK_W          = 16;
  localparam int WGT_W           = 10;
  localparam int LAT_W           = 11;
  localparam int GRAN_W          = 5;
  localparam int CFG_IDX_W       = 1;
  localparam int WGT_MAX         = 819;

  localparam logic [LAT_W-1:0]  LAT_RESET  = 11'd32;
  localparam logic [GRAN_W-1:0] GRAN_RESET = 5'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_PICK    = 2'd1,
    CMD_PREEMPT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATENCY = 1'b0,
    CFG_GRAN    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // One queue entry as held in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [VR_W-1:0]  vr;
    logic [WGT_W-1:0] wgt;
  } slot_t;

  // Weight for a nice value, clamped to 0..NICE_MAX; floor(1024 / 1.25^(n+1)).
  function automatic logic [WGT_W-1:0] weight_of(input logic signed [NICE_W-1:0] nice);
    logic [4:0] n;
    logic [WGT_W-1:0] w;
    if (nice < 0) n = 5'd0;
    else if (nice > NICE_W'(NICE_MAX)) n = 5'(NICE_MAX);
    else n = nice[4:0];
    case (n)
      5'd0:  w = 10'd819;
      5'd1:  w = 10'd655;
      5'd2:  w = 10'd524;
      5'd3:  w = 10'd419;
      5'd4:  w = 10'd335;
      5'd5:  w = 10'd268;
      5'd6:  w = 10'd214;
      5'd7:  w = 10'd171;
      5'd8:  w = 10'd137;
      5'd9:  w = 10'd109;
      5'd10: w = 10'd87;
      5'd11: w = 10'd70;
      5'd12: w = 10'd56;
      5'd13: w = 10'd45;
      5'd14: w = 10'd36;
      5'd15: w = 10'd28;
      5'd16: w = 10'd23;
      5'd17: w = 10'd18;
      5'd18: w = 10'd14;
      5'd19: w = 10'd11;
      5'd20: w = 10'd9;
      5'd21: w = 10'd7;
      5'd22: w = 10'd6;
      5'd23: w = 10'd4;
      5'd24: w = 10'd3;
      5'd25: w = 10'd3;
      5'd26: w = 10'd2;
      default: w = 10'd1;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/fair_share_run_queue.sv -----
`timescale 1ns / 1ps
// Fair-share run queue: slot memory in insertion order, sequencer, divider for pick.
// Depends on fsrq_pkg.
//
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_stall   cmd, task_id, vruntime, nice_level,
//                                          run_ticks, slice_limit
//  out_     output     out_valid/out_stall ok, picked_id, time_slice, preempt
//  cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// Insert and no-op go straight to the result; a preempt check may scan the slot memory.
// Pick on a non-empty queue runs a scan of the slot memory, a 26-step restoring divider,
// and a compaction sweep, all through one memory read port.
// Reset is synchronous; it empties the queue and loads default registers.
// in_stall is high while a transaction is in work; a result held by out_stall sits in the
// output register; the next input is accepted, but its result waits in ST_DONE meanwhile.
module fair_share_run_queue
  import fsrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [ID_W-1:0]          in_task_id,
  input  logic [VR_W-1:0]          in_vruntime,
  input  logic signed [NICE_W-1:0] in_nice_level,
  input  logic [TICK_W-1:0]        in_run_ticks,
  input  logic [TICK_W-1:0]        in_slice_limit,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_ok,
  output logic [ID_W-1:0]          out_picked_id,
  output logic [TICK_W-1:0]        out_time_slice,
  output logic                     out_preempt,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [LAT_W-1:0]         cfg_wdata
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int WSW  = $clog2(QUEUE_DEPTH * WGT_MAX + 1);
  localparam int PW   = TICK_W + WGT_W;
  localparam int SW   = $clog2(PW);
  localparam int PGW  = CW + GRAN_W;

  // Slot memory.
  slot_t mem [QUEUE_DEPTH];
  slot_t rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic [AW-1:0] rd_addr;

  state_t state_r, state_nxt;

  logic [CW-1:0]     tc_r;
  logic [WSW-1:0]    ws_r;
  logic [WSW-1:0]    div_r;
  logic [LAT_W-1:0]  lat_r;
  logic [GRAN_W-1:0] gran_r;
  logic [TICK_W-1:0] period_r;

  cmd_t              cmd_r;
  logic [VR_W-1:0]   vr_r;
  logic [TICK_W-1:0] run_r;

  logic [CW-1:0]    cnt_r;
  logic             pend_r;
  logic [AW-1:0]    pend_idx_r;
  logic [AW-1:0]    best_idx_r;
  slot_t            best_r;

  logic [PW-1:0]  prod_r;
  logic [WSW-1:0] rem_r;
  logic [SW-1:0]  step_r;

  logic              res_ok_r, res_pre_r;
  logic [ID_W-1:0]   res_id_r;
  logic [TICK_W-1:0] res_slice_r;

  logic              out_valid_r, out_ok_r, out_pre_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TICK_W-1:0] out_slice_r;

  logic in_acc, out_free, scan_done, rule_limit, gran_ok;
  logic [PGW-1:0]   tg;
  logic [WSW:0]     rem_sh;
  logic             q_bit;
  logic [PW-1:0]    q_nxt;
  logic [WGT_W-1:0] ins_w;

  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign scan_done  = (cnt_r >= tc_r) && !pend_r;
  assign gran_ok    = (in_run_ticks >= TICK_W'(gran_r));
  assign rule_limit = (in_run_ticks >= in_slice_limit) && gran_ok;
  assign tg         = PGW'(tc_r) * PGW'(gran_r);
  assign ins_w      = weight_of(in_nice_level);

  // One restoring division step.
  assign rem_sh = {rem_r, prod_r[PW-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_r});
  assign q_nxt  = {prod_r[PW-2:0], q_bit};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_cmd))
            CMD_PICK:    state_nxt = (tc_r == '0) ? ST_DONE : ST_SCAN;
            CMD_PREEMPT: state_nxt = (rule_limit || tc_r == '0) ? ST_DONE : ST_SCAN;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN:  if (scan_done) state_nxt = (cmd_r == CMD_PICK) ? ST_PREP : ST_DONE;
      ST_PREP:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = (div_r == '0) ? ST_SHIFT : ST_DIV;
      ST_DIV:   if (step_r == SW'(PW - 1)) state_nxt = ST_SHIFT;
      ST_SHIFT: if (scan_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    rd_addr   = cnt_r[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = tc_r[AW-1:0];
    mem_wdata = rd_data_r;
    case (state_r)
      ST_IDLE: begin
        mem_we    = in_acc && (cmd_t'(in_cmd) == CMD_INSERT) && (tc_r < CW'(QUEUE_DEPTH));
        mem_wdata = '{id: in_task_id, vr: in_vruntime, wgt: ins_w};
      end
      ST_SHIFT: begin
        mem_we    = pend_r;
        mem_waddr = pend_idx_r - AW'(1);
      end
      default: ;
    endcase
  end

  // Slot memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath and queue state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r        <= '0;
      ws_r        <= '0;
      lat_r       <= LAT_RESET;
      gran_r      <= GRAN_RESET;
      period_r    <= TICK_W'(LAT_RESET);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The user must issue configuration writes only while idle; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LATENCY: begin
            lat_r    <= cfg_wdata;
            period_r <= TICK_W'(cfg_wdata);
          end
          CFG_GRAN: gran_r <= cfg_wdata[GRAN_W-1:0];
          default: ;
        endcase
      end

      // Output register.
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        out_ok_r    <= res_ok_r;
        out_id_r    <= res_id_r;
        out_slice_r <= res_slice_r;
        out_pre_r   <= res_pre_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r       <= cmd_t'(in_cmd);
            vr_r        <= in_vruntime;
            run_r       <= in_run_ticks;
            cnt_r       <= '0;
            pend_r      <= 1'b0;
            res_ok_r    <= mem_we;
            res_id_r    <= '0;
            res_slice_r <= '0;
            res_pre_r   <= (cmd_t'(in_cmd) == CMD_PREEMPT) && rule_limit;
            if (mem_we) begin
              tc_r     <= tc_r + CW'(1);
              ws_r     <= ws_r + WSW'(ins_w);
            end
          end
        end
        ST_SCAN: begin
          if (cnt_r < tc_r) cnt_r <= cnt_r + CW'(1);
          pend_r     <= (cnt_r < tc_r);
          pend_idx_r <= cnt_r[AW-1:0];
          if (pend_r && (pend_idx_r == '0 || rd_data_r.vr < best_r.vr)) begin
            best_r     <= rd_data_r;
            best_idx_r <= pend_idx_r;
          end
          if (scan_done && cmd_r == CMD_PREEMPT)
            res_pre_r <= (vr_r > best_r.vr) && (run_r == '0 || run_r >= TICK_W'(gran_r));
        end
        ST_PREP: begin
          // Widen the period when count > latency / granularity.
          if (gran_r != '0 && tg > PGW'(lat_r)) period_r <= TICK_W'(tg);
          div_r    <= ws_r;
          ws_r     <= ws_r - ((WSW'(best_r.wgt) <= ws_r) ? WSW'(best_r.wgt) : ws_r);
          res_ok_r <= 1'b1;
          res_id_r <= best_r.id;
          cnt_r    <= CW'(best_idx_r) + CW'(1);
          pend_r   <= 1'b0;
        end
        ST_MUL: begin
          prod_r <= PW'(period_r) * PW'(best_r.wgt);
          rem_r  <= '0;
          step_r <= '0;
        end
        ST_DIV: begin
          prod_r <= q_nxt;
          rem_r  <= q_bit ? WSW'(rem_sh - {1'b0, div_r}) : WSW'(rem_sh);
          step_r <= step_r + SW'(1);
          if (step_r == SW'(PW - 1)) res_slice_r <= q_nxt[TICK_W-1:0];
        end
        ST_SHIFT: begin
          // Close the gap: move each later entry down by one slot.
          if (cnt_r < tc_r) cnt_r <= cnt_r + CW'(1);
          pend_r     <= (cnt_r < tc_r);
          pend_idx_r <= cnt_r[AW-1:0];
          if (scan_done) tc_r <= tc_r - CW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_picked_id  = out_id_r;
  assign out_time_slice = out_slice_r;
  assign out_preempt    = out_pre_r;

endmodule

// ----- hdl/fsrq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the fair-share run queue, bound to the top level.
// Depends on fsrq_pkg.
module fsrq_checker
  import fsrq_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_ok,
  input logic [ID_W-1:0]   out_picked_id,
  input logic [TICK_W-1:0] out_time_slice,
  input logic              out_preempt
);

  // A held result keeps its id and slice.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_time_slice) && $stable(out_picked_id))
    else $error("stalled result changed");

  // Every accepted transaction keeps the input busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not busy after accept");

  // A failed transaction carries no id and no slice.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_picked_id == '0 && out_time_slice == '0)
    else $error("failed result has payload");

  // A preemption answer never comes with ok.
  a_pre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_preempt |-> !out_ok)
    else $error("preempt with ok");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fair_share_run_queue fsrq_checker u_fsrq_checker (.*);
